// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// Two wrappers around assert property, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/fpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpcc_pkg: shared types and constants of the frame checker
// Field widths, frame limits, verdict codes and the crc-8 byte step.
// ----------------------------------------------------------------------------
package fpcc_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 9;
	localparam int FLEN_W   = 10;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int OUT_W    = 32;

	localparam logic [POS_W-1:0]  POS_SAT    = '1;
	localparam logic [FLEN_W-1:0] MIN_FRAME  = 10'd5;
	localparam logic [FLEN_W-1:0] MAX_FRAME  = 10'd255;
	localparam logic [FLEN_W-1:0] HEAD_BYTES = 10'd3;

	localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
	localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h55;
	localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hAA;

	// register index, taken from paddr[2]
	localparam logic REG_HEAD = 1'b0;
	localparam logic REG_TAIL = 1'b1;

	typedef enum logic [2:0] {
		CAUSE_OK      = 3'd0,
		CAUSE_SHORT   = 3'd1,
		CAUSE_LONG    = 3'd2,
		CAUSE_HEAD    = 3'd3,
		CAUSE_TAIL    = 3'd4,
		CAUSE_OVERRUN = 3'd5,
		CAUSE_CRC     = 3'd6
	} fail_cause_t;

	typedef struct packed {
		logic [BYTE_W-1:0] head_value;
		logic [BYTE_W-1:0] tail_value;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              last_byte;
	} item_t;

	typedef struct packed {
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_done;
		logic              frame_ok;
		logic [BYTE_W-1:0] command_id;
		logic [BYTE_W-1:0] payload_count;
		fail_cause_t       fail_cause;
	} result_t;

	// msb-first crc-8 over one byte, no reflection
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/fpcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fpcc_cfg_regs: configuration registers
// APB-style write and read of the head and tail byte values.
// ----------------------------------------------------------------------------
module fpcc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fpcc_pkg::ADDR_W-1:0] paddr,
	input  logic [fpcc_pkg::DATA_W-1:0] pwdata,
	output logic [fpcc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output fpcc_pkg::cfg_t              cfg
);

	logic [fpcc_pkg::BYTE_W-1:0] head_q;
	logic [fpcc_pkg::BYTE_W-1:0] tail_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= fpcc_pkg::HEAD_RESET;
			tail_q <= fpcc_pkg::TAIL_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				fpcc_pkg::REG_HEAD: head_q <= pwdata[fpcc_pkg::BYTE_W-1:0];
				fpcc_pkg::REG_TAIL: tail_q <= pwdata[fpcc_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fpcc_pkg::REG_HEAD: prdata = {{(fpcc_pkg::DATA_W-fpcc_pkg::BYTE_W){1'b0}}, head_q};
			fpcc_pkg::REG_TAIL: prdata = {{(fpcc_pkg::DATA_W-fpcc_pkg::BYTE_W){1'b0}}, tail_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.head_value = head_q;
	assign cfg.tail_value = tail_q;

endmodule

// ===== rtl/core/fpcc_in_stage.sv =====
// ----------------------------------------------------------------------------
// fpcc_in_stage: input register
// Captures a byte request per cycle unless stalled, holds it until it moves on.
// ----------------------------------------------------------------------------
module fpcc_in_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fpcc_pkg::BYTE_W-1:0] s_tdata,
	input  logic                        s_tlast,
	input  logic                        advance,
	output logic                        valid_s1,
	output fpcc_pkg::item_t             item_s1
);

	// free when empty or when the held byte leaves this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.in_byte   <= s_tdata;
			item_s1.last_byte <= s_tlast;
		end
	end

endmodule

// ===== rtl/core/fpcc_frame_check.sv =====
// ----------------------------------------------------------------------------
// fpcc_frame_check: per-byte frame state and verdict
// Tracks the position in the frame, header bytes and crc; builds the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpcc_frame_check (
	input  logic                clk,
	input  logic                arst_n,
	input  fpcc_pkg::cfg_t      cfg,
	input  fpcc_pkg::item_t     item_s1,
	input  logic                advance,
	output fpcc_pkg::result_t   result
);

	logic [fpcc_pkg::POS_W-1:0]  pos_q;
	logic [fpcc_pkg::BYTE_W-1:0] crc_q;
	logic [fpcc_pkg::BYTE_W-1:0] cmd_q;
	logic [fpcc_pkg::BYTE_W-1:0] len_q;
	logic [fpcc_pkg::BYTE_W-1:0] prev_q;
	logic                        head_ok_q;

	logic [fpcc_pkg::BYTE_W-1:0] b;
	logic                        last;
	logic                        head_ok_n;
	logic [fpcc_pkg::BYTE_W-1:0] cmd_n;
	logic [fpcc_pkg::BYTE_W-1:0] len_n;
	logic [fpcc_pkg::BYTE_W-1:0] crc_n;
	logic [fpcc_pkg::POS_W-1:0]  pos_n;
	logic                        pay;
	logic [fpcc_pkg::FLEN_W-1:0] frame_len;
	logic [fpcc_pkg::FLEN_W-1:0] pay_end;
	logic [fpcc_pkg::FLEN_W-1:0] decl_end;
	fpcc_pkg::fail_cause_t       cause;

	assign b    = item_s1.in_byte;
	assign last = item_s1.last_byte;

	assign head_ok_n = (pos_q == 9'd0) ? (b == cfg.head_value) : head_ok_q;
	assign cmd_n     = (pos_q == 9'd1) ? b : cmd_q;
	assign len_n     = (pos_q == 9'd2) ? b : len_q;

	// payload occupies positions 3 .. 3+length-1
	assign pay_end = fpcc_pkg::FLEN_W'(len_q) + fpcc_pkg::HEAD_BYTES;
	assign pay     = (fpcc_pkg::FLEN_W'(pos_q) >= fpcc_pkg::HEAD_BYTES)
		&& (fpcc_pkg::FLEN_W'(pos_q) < pay_end);
	assign crc_n   = pay ? fpcc_pkg::crc8_step(crc_q, b) : crc_q;

	assign frame_len = fpcc_pkg::FLEN_W'(pos_q) + 10'd1;
	assign decl_end  = fpcc_pkg::FLEN_W'(len_n) + fpcc_pkg::HEAD_BYTES;
	assign pos_n     = (pos_q == fpcc_pkg::POS_SAT) ? pos_q : pos_q + 9'd1;

	always_comb begin
		priority if (frame_len < fpcc_pkg::MIN_FRAME) begin
			cause = fpcc_pkg::CAUSE_SHORT;
		end else if (frame_len > fpcc_pkg::MAX_FRAME) begin
			cause = fpcc_pkg::CAUSE_LONG;
		end else if (!head_ok_n) begin
			cause = fpcc_pkg::CAUSE_HEAD;
		end else if (b != cfg.tail_value) begin
			cause = fpcc_pkg::CAUSE_TAIL;
		end else if (decl_end > frame_len) begin
			cause = fpcc_pkg::CAUSE_OVERRUN;
		end else if (crc_n != prev_q) begin
			cause = fpcc_pkg::CAUSE_CRC;
		end else begin
			cause = fpcc_pkg::CAUSE_OK;
		end
	end

	always_comb begin
		result.payload_valid = pay;
		result.payload_byte  = pay ? b : '0;
		result.frame_done    = last;
		result.frame_ok      = last && (cause == fpcc_pkg::CAUSE_OK);
		result.command_id    = last ? cmd_n : '0;
		result.payload_count = last ? len_n : '0;
		result.fail_cause    = last ? cause : fpcc_pkg::CAUSE_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= '0;
			cmd_q     <= '0;
			len_q     <= '0;
			prev_q    <= '0;
			head_ok_q <= 1'b0;
		end else if (advance) begin
			if (last) begin
				pos_q     <= '0;
				crc_q     <= '0;
				cmd_q     <= '0;
				len_q     <= '0;
				prev_q    <= '0;
				head_ok_q <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				crc_q     <= crc_n;
				cmd_q     <= cmd_n;
				len_q     <= len_n;
				prev_q    <= b;
				head_ok_q <= head_ok_n;
			end
		end
	end

	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, advance && last, (pos_q == 9'd0) && (crc_q == 8'd0))
	`ASSERT_NEXT(a_pos_step, clk, arst_n, advance && !last && (pos_q != fpcc_pkg::POS_SAT), pos_q == $past(pos_q) + 9'd1)
	`ASSERT_IMPL(a_pay_after_header, clk, arst_n, pay, pos_q >= 9'd3)
	`ASSERT_IMPL(a_ok_matches_cause, clk, arst_n, last, result.frame_ok == (result.fail_cause == fpcc_pkg::CAUSE_OK))

endmodule

// ===== rtl/core/fpcc_out_stage.sv =====
// ----------------------------------------------------------------------------
// fpcc_out_stage: result register
// Holds one result for the output channel and packs it onto the bus.
// ----------------------------------------------------------------------------
module fpcc_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  fpcc_pkg::result_t          result,
	output logic                       advance,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [fpcc_pkg::OUT_W-1:0] m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	logic              valid_q;
	fpcc_pkg::result_t res_q;

	// take a new result when empty or when the held one is taken now
	assign advance = valid_s1 && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = res_q.frame_done;
	assign m_tuser  = res_q.payload_valid;
	assign m_tdata  = {4'd0, res_q.fail_cause, res_q.payload_count, res_q.command_id,
		res_q.frame_ok, res_q.payload_byte};

endmodule

// ===== rtl/core/framed_packet_crc8_checker_unit.sv =====
// ----------------------------------------------------------------------------
// framed_packet_crc8_checker_unit: byte-serial command frame checker
// Checks head, tail, length and crc-8 of each frame and forwards payload.
// ----------------------------------------------------------------------------
// Frame bytes arrive on the s_ stream, one byte per request, s_tlast on the
// last byte of each frame. Every byte gives exactly one result on the m_
// stream: m_tuser flags a forwarded payload byte, m_tlast marks the verdict
// result of the frame's last byte, which also carries ok, cause, command and
// declared length. Results come out in byte order.
// A byte accepted into the input register goes through the crc step and the
// checks into the result register, which drives m_tvalid: two register
// stages. One byte per cycle is sustained while the receiver takes results;
// the crc-8 byte step is combinational. On a receiver stall the result
// register holds, the input register takes one more byte if empty, and
// s_tready drops until the result is taken. Reset empties both stages,
// clears the frame state, loads head 0x55 and tail 0xAA. The user must write
// head (0x0) and tail (0x4) over APB between frames; the block does not check.
// ----------------------------------------------------------------------------
module framed_packet_crc8_checker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// s_tdata: [7:0] in_byte
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fpcc_pkg::BYTE_W-1:0] s_tdata,
	input  logic                        s_tlast,
	// m_tdata: [7:0] payload_byte, [8] frame_ok, [16:9] command_id,
	// [24:17] payload_count, [27:25] fail_cause, [31:28] zero
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fpcc_pkg::OUT_W-1:0]  m_tdata,
	output logic                        m_tlast,
	// m_tuser: [0] payload_valid
	output logic                        m_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fpcc_pkg::ADDR_W-1:0] paddr,
	input  logic [fpcc_pkg::DATA_W-1:0] pwdata,
	output logic [fpcc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	fpcc_pkg::cfg_t    cfg;
	fpcc_pkg::item_t   item_s1;
	fpcc_pkg::result_t result;
	logic              valid_s1;
	logic              advance;

	fpcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpcc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fpcc_frame_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item_s1 (item_s1),
		.advance (advance),
		.result  (result)
	);

	fpcc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== bench/framed_packet_crc8_checker_unit_test.sv =====
// ----------------------------------------------------------------------------
// framed_packet_crc8_checker_unit_test: self-checking bench of the frame checker
// Streams command frames byte by byte: a directed set of short, bad head, bad
// tail, overrun and crc error frames, then random frames under several head
// and tail settings and idle patterns. A local frame checker predicts every
// result, which is compared field by field in order.
// ----------------------------------------------------------------------------
module framed_packet_crc8_checker_unit_test;
	import fpcc_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tlast;
	logic                m_tuser;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	framed_packet_crc8_checker_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// frame bytes waiting to be sent, and results predicted for accepted bytes
	item_t   frame_bytes[$];
	result_t pending_outputs[$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      mismatch_count = 0;

	// checker state as seen by the bench
	logic [BYTE_W-1:0] cfg_head = HEAD_RESET;
	logic [BYTE_W-1:0] cfg_tail = TAIL_RESET;
	logic [POS_W-1:0]  frame_pos = '0;
	logic [BYTE_W-1:0] crc_acc = '0;
	logic [BYTE_W-1:0] cmd_hold = '0;
	logic [BYTE_W-1:0] len_hold = '0;
	logic [BYTE_W-1:0] prior_byte = '0;
	logic              head_match = 1'b0;

	function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] acc,
		input logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] c;
		c = acc ^ d;
		repeat (BYTE_W) c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY)
			: {c[BYTE_W-2:0], 1'b0};
		return c;
	endfunction

	// one byte through the frame checker, returns the result it gives
	function automatic result_t frame_check_step(input logic [BYTE_W-1:0] b, input logic last);
		result_t     r;
		int          flen;
		fail_cause_t cause;
		r = '0;
		if (frame_pos == 0) begin
			head_match = (b == cfg_head);
		end else if (frame_pos == 1) begin
			cmd_hold = b;
		end else if (frame_pos == 2) begin
			len_hold = b;
		end else if (int'(frame_pos) - 3 < int'(len_hold)) begin
			crc_acc = crc8_next(crc_acc, b);
			r.payload_valid = 1'b1;
			r.payload_byte = b;
		end
		if (last) begin
			flen = int'(frame_pos) + 1;
			if (flen < int'(MIN_FRAME))
				cause = CAUSE_SHORT;
			else if (flen > int'(MAX_FRAME))
				cause = CAUSE_LONG;
			else if (!head_match)
				cause = CAUSE_HEAD;
			else if (b != cfg_tail)
				cause = CAUSE_TAIL;
			else if (int'(HEAD_BYTES) + int'(len_hold) > flen)
				cause = CAUSE_OVERRUN;
			else if (crc_acc != prior_byte)
				cause = CAUSE_CRC;
			else
				cause = CAUSE_OK;
			r.frame_done = 1'b1;
			r.frame_ok = (cause == CAUSE_OK);
			r.command_id = cmd_hold;
			r.payload_count = len_hold;
			r.fail_cause = cause;
			frame_pos = '0;
			crc_acc = '0;
			cmd_hold = '0;
			len_hold = '0;
			prior_byte = '0;
			head_match = 1'b0;
		end else begin
			prior_byte = b;
			if (frame_pos != POS_SAT)
				frame_pos = frame_pos + 1'b1;
		end
		return r;
	endfunction

	// sender: holds a request until taken, then maybe idles
	always @(posedge clk or negedge arst_n) begin
		item_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				pending_outputs.push_back(frame_check_step(s_tdata, s_tlast));
			if (!s_tvalid || s_tready) begin
				if (frame_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = frame_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_req.in_byte;
					s_tlast <= next_req.last_byte;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	// receiver: compares each taken result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_outputs.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with none expected, expected none, actual tdata %h",
						$time, m_tdata);
				end else begin
					want = pending_outputs.pop_front();
					check_field("payload_valid", want.payload_valid, m_tuser);
					check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
					check_field("frame_done", want.frame_done, m_tlast);
					check_field("frame_ok", want.frame_ok, m_tdata[8]);
					check_field("command_id", want.command_id, m_tdata[16:9]);
					check_field("payload_count", want.payload_count, m_tdata[24:17]);
					check_field("fail_cause", want.fail_cause, m_tdata[27:25]);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic bit frames_drained();
		return frame_bytes.size() == 0 && !s_tvalid && pending_outputs.size() == 0;
	endfunction

	task automatic reg_write(input logic reg_sel, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {{(DATA_W-BYTE_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_HEAD)
			cfg_head = val;
		else
			cfg_tail = val;
	endtask

	task automatic push_frame(input logic [BYTE_W-1:0] fr[$]);
		foreach (fr[i])
			frame_bytes.push_back('{in_byte: fr[i], last_byte: (i == fr.size() - 1)});
	endtask

	// head, command, declared length, real payload, padding, crc, tail
	task automatic queue_frame(input logic [BYTE_W-1:0] head_b, input logic [BYTE_W-1:0] decl_len,
		input int pay_n, input int pad_n, input bit corrupt_crc, input logic [BYTE_W-1:0] tail_b);
		logic [BYTE_W-1:0] fr[$];
		logic [BYTE_W-1:0] crc;
		logic [BYTE_W-1:0] b;
		crc = '0;
		fr.push_back(head_b);
		fr.push_back(8'($urandom));
		fr.push_back(decl_len);
		for (int i = 0; i < pay_n; i++) begin
			b = 8'($urandom);
			fr.push_back(b);
			crc = crc8_next(crc, b);
		end
		repeat (pad_n) fr.push_back(8'($urandom));
		fr.push_back(corrupt_crc ? crc ^ 8'($urandom_range(255, 1)) : crc);
		fr.push_back(tail_b);
		push_frame(fr);
	endtask

	task automatic queue_noise(input int n);
		logic [BYTE_W-1:0] fr[$];
		repeat (n) fr.push_back(8'($urandom));
		push_frame(fr);
	endtask

	task automatic queue_random_frame();
		int roll;
		int pay_n;
		roll = $urandom_range(99);
		pay_n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
		if (roll < 55)
			queue_frame(cfg_head, 8'(pay_n), pay_n, 0, 0, cfg_tail);
		else if (roll < 63)
			queue_frame(cfg_head, 8'(pay_n), pay_n, 0, 1, cfg_tail);
		else if (roll < 68)
			queue_frame(cfg_head ^ 8'($urandom_range(255, 1)), 8'(pay_n), pay_n, 0, 0, cfg_tail);
		else if (roll < 73)
			queue_frame(cfg_head, 8'(pay_n), pay_n, 0, 0, cfg_tail ^ 8'($urandom_range(255, 1)));
		else if (roll < 78)
			// declared payload runs past the tail
			queue_frame(cfg_head, 8'(pay_n + $urandom_range(10, 3)), pay_n, 0, 0, cfg_tail);
		else if (roll < 83)
			// declared payload covers crc and maybe tail
			queue_frame(cfg_head, 8'(pay_n + $urandom_range(2, 1)), pay_n, 0, 0, cfg_tail);
		else if (roll < 88)
			queue_frame(cfg_head, 8'(pay_n), pay_n, $urandom_range(4, 1), 0, cfg_tail);
		else if (roll < 94)
			queue_noise($urandom_range(4, 1));
		else
			queue_noise($urandom_range(20, 1));
	endtask

	initial begin
		logic [BYTE_W-1:0] any_b;
		int target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			while (!frames_drained()) @(posedge clk);
			repeat (4) @(posedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			case (ph)
				1: begin reg_write(REG_HEAD, 8'h00); reg_write(REG_TAIL, 8'hFF); end
				2: begin reg_write(REG_HEAD, 8'hFF); reg_write(REG_TAIL, 8'h00); end
				3: begin reg_write(REG_HEAD, 8'($urandom)); reg_write(REG_TAIL, 8'($urandom)); end
				4: begin
					// head and tail the same byte
					any_b = 8'($urandom);
					reg_write(REG_HEAD, any_b);
					reg_write(REG_TAIL, any_b);
				end
				default: ;
			endcase
			target = 40;
			if (ph == 0) begin
				queue_noise(1);
				queue_frame(cfg_head, 8'h00, 0, 0, 0, cfg_tail);
				void'(frame_bytes.pop_back());
				frame_bytes[$].last_byte = 1'b1;
				queue_frame(cfg_head, 8'h00, 0, 0, 0, cfg_tail);
				queue_frame(~cfg_head, 8'h00, 0, 0, 0, cfg_tail);
				queue_frame(cfg_head, 8'h00, 0, 0, 0, ~cfg_tail);
				queue_frame(cfg_head, 8'h03, 0, 0, 0, cfg_tail);
				queue_frame(cfg_head, 8'h01, 1, 0, 1, cfg_tail);
				queue_frame(cfg_head, 8'hFF, 0, 0, 0, cfg_tail);
			end else if (ph == 2) begin
				// one byte over the limit
				queue_frame(cfg_head, 8'd251, 251, 0, 0, cfg_tail);
			end
			target = target + frame_bytes.size();
			while (frame_bytes.size() < target) queue_random_frame();
		end
		while (!frames_drained()) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && pending_outputs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fpcc_pkg.sv
rtl/core/fpcc_cfg_regs.sv
rtl/core/fpcc_in_stage.sv
rtl/core/fpcc_frame_check.sv
rtl/core/fpcc_out_stage.sv
rtl/core/framed_packet_crc8_checker_unit.sv
bench/framed_packet_crc8_checker_unit_test.sv
